// ----- rtl/broadcast_ring_fifo_macros.svh -----
// Assertion shorthands used by the RTL. Each expands to a labeled concurrent
// assertion clocked by clk and held off while rst_n is low.
`ifndef BROADCAST_RING_FIFO_MACROS_SVH
`define BROADCAST_RING_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("broadcast_ring_fifo: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("broadcast_ring_fifo: next-cycle check failed");

`endif

// ----- rtl/brf_pkg.sv -----
package brf_pkg;

  // Default sizing of the ring and of the reader set.
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned READERS_DEF = 8;

  // Field widths fixed by the interface.
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned RID_W     = 3;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned SLOTS_W   = 5;
  localparam int unsigned RCNT_W    = 4;
  localparam int unsigned LIMIT_W   = 32;

  // Reset values of the configuration registers.
  localparam logic [SLOTS_W-1:0] SLOTS_RST  = SLOTS_W'(16);
  localparam logic [RCNT_W-1:0]  RCNT_RST   = RCNT_W'(8);
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_READER_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LIMIT  = CFG_IDX_W'(2);

  // Request queue between front and back, and result queue at the output.
  localparam int unsigned RQ_DEPTH = 2;
  localparam int unsigned RQ_PTR_W = 1;
  localparam int unsigned RQ_CNT_W = 2;
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = 2;
  localparam int unsigned OQ_CNT_W = 3;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOTHING = 2'd1,
    ST_FULL    = 2'd2,
    ST_LIMIT   = 2'd3
  } status_t;

  // A classified request as it sits in the queue between front and back.
  typedef struct packed {
    op_t                       op;
    logic [RID_W-1:0]          reader_id;
    logic                      rid_bad;
    logic signed [VALUE_W-1:0] write_value;
  } req_t;

  // One result as it sits in the output queue.
  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]          slot_position;
  } res_t;

endpackage

// ----- rtl/brf_front.sv -----
module brf_front #(
  parameter int unsigned READERS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic                              in_operation,
  input  logic [brf_pkg::RID_W-1:0]         in_reader_id,
  input  logic signed [brf_pkg::VALUE_W-1:0] in_write_value,
  output brf_pkg::req_t                     req,
  output logic                              req_vld,
  input  logic                              req_take
);
  import brf_pkg::*;

  req_t                q_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r;
  logic [RQ_PTR_W-1:0] rd_ptr_r;
  logic [RQ_CNT_W-1:0] cnt_r;
  req_t                req_in;
  logic                do_push;
  logic                do_pop;

  // Classify on the way in: a reader id outside the reader set can never read.
  always_comb begin
    req_in.op          = op_t'(in_operation);
    req_in.reader_id   = in_reader_id;
    req_in.rid_bad     = (32'(in_reader_id) >= 32'(READERS));
    req_in.write_value = in_write_value;
  end

  assign full    = (cnt_r == RQ_CNT_W'(RQ_DEPTH));
  assign req_vld = (cnt_r != '0);
  assign req     = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = req_take && req_vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + RQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + RQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + RQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - RQ_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/brf_back.sv -----
`include "broadcast_ring_fifo_macros.svh"

module brf_back #(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned READERS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [brf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brf_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  brf_pkg::req_t                     req,
  input  logic                              req_vld,
  output logic                              req_take,
  input  logic                              oq_room,
  output logic                              res_vld,
  output brf_pkg::res_t                     res
);
  import brf_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned RC_W  = $clog2(READERS + 1);

  // Configuration registers.
  logic [SLOTS_W-1:0] slots_r;
  logic [RCNT_W-1:0]  rcnt_r;
  logic [LIMIT_W-1:0] limit_r;

  // Ring state.
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [READERS-1:0] mask_r, mask_nxt;
  logic [RC_W-1:0]    done_r, done_nxt;
  logic [LIMIT_W-1:0] writes_r, writes_nxt;

  // Result stage.
  logic               res_vld_r;
  status_t            res_status_r, res_status_nxt;
  logic [POS_W-1:0]   res_pos_r, res_pos_nxt;
  logic               res_rd_r;
  logic [VALUE_W-1:0] rd_data_r;

  logic               exec;
  logic [CNT_W-1:0]   eff_slots;
  logic [RC_W-1:0]    eff_readers;
  logic [CNT_W-1:0]   head_inc, tail_inc;
  logic [IDX_W-1:0]   head_adv, tail_adv;
  logic [RC_W-1:0]    done_inc;
  logic [READERS-1:0] rid_bit;
  logic               is_full, at_limit, seen;
  logic               wr_ok, rd_ok, frees;

  assign exec     = req_vld && oq_room;
  assign req_take = exec;

  always_comb begin
    // Registers outside their range saturate to the legal span.
    if (slots_r == '0) begin
      eff_slots = CNT_W'(1);
    end else if (32'(slots_r) > 32'(DEPTH)) begin
      eff_slots = CNT_W'(DEPTH);
    end else begin
      eff_slots = CNT_W'(slots_r);
    end
    if (rcnt_r == '0) begin
      eff_readers = RC_W'(1);
    end else if (32'(rcnt_r) > 32'(READERS)) begin
      eff_readers = RC_W'(READERS);
    end else begin
      eff_readers = RC_W'(rcnt_r);
    end

    head_inc = CNT_W'(head_r) + CNT_W'(1);
    tail_inc = CNT_W'(tail_r) + CNT_W'(1);
    head_adv = (head_inc >= eff_slots) ? '0 : IDX_W'(head_inc);
    tail_adv = (tail_inc >= eff_slots) ? '0 : IDX_W'(tail_inc);

    rid_bit  = READERS'(1) << req.reader_id;
    is_full  = (fill_r >= eff_slots);
    at_limit = (writes_r >= limit_r);
    seen     = |(mask_r & rid_bit);
    wr_ok    = exec && (req.op == OP_WRITE) && !is_full && !at_limit;
    rd_ok    = exec && (req.op == OP_READ) && !req.rid_bad && (fill_r != '0) && !seen;
    done_inc = done_r + RC_W'(1);
    frees    = (done_inc >= eff_readers);

    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    mask_nxt   = mask_r;
    done_nxt   = done_r;
    writes_nxt = writes_r;

    if (wr_ok) begin
      tail_nxt   = tail_adv;
      fill_nxt   = fill_r + CNT_W'(1);
      writes_nxt = writes_r + LIMIT_W'(1);
    end
    if (rd_ok) begin
      if (frees) begin
        head_nxt = head_adv;
        mask_nxt = '0;
        done_nxt = '0;
        fill_nxt = fill_r - CNT_W'(1);
      end else begin
        mask_nxt = mask_r | rid_bit;
        done_nxt = done_inc;
      end
    end

    if (req.op == OP_WRITE) begin
      res_pos_nxt = POS_W'(tail_r);
      if (is_full) begin
        res_status_nxt = ST_FULL;
      end else if (at_limit) begin
        res_status_nxt = ST_LIMIT;
      end else begin
        res_status_nxt = ST_OK;
      end
    end else begin
      res_pos_nxt    = POS_W'(head_r);
      res_status_nxt = rd_ok ? ST_OK : ST_NOTHING;
    end
  end

  // Single-port slot memory: one write or one registered read per request.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[tail_r] <= req.write_value;
    end
    if (rd_ok) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_rd_r     <= rd_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r   <= SLOTS_RST;
      rcnt_r    <= RCNT_RST;
      limit_r   <= LIMIT_RST;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      mask_r    <= '0;
      done_r    <= '0;
      writes_r  <= '0;
      res_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOTS_IN_USE: slots_r <= cfg_data[SLOTS_W-1:0];
          CFG_READER_COUNT: rcnt_r  <= cfg_data[RCNT_W-1:0];
          CFG_WRITE_LIMIT:  limit_r <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
      mask_r    <= mask_nxt;
      done_r    <= done_nxt;
      writes_r  <= writes_nxt;
      res_vld_r <= exec;
    end
  end

  assign res_vld           = res_vld_r;
  assign res.status        = res_status_r;
  assign res.read_value    = res_rd_r ? rd_data_r : '0;
  assign res.slot_position = res_pos_r;

  // The done count always matches the number of readers marked in the mask.
  `BRF_ASSERT_SAME(a_mask_count, 1'b1, $countones(mask_r) == 32'(done_r))
  // An empty ring carries no partial reader bookkeeping.
  `BRF_ASSERT_SAME(a_empty_mask, fill_r == '0, mask_r == '0)
  // The ring never holds more entries than it has slots.
  `BRF_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= CNT_W'(DEPTH))
  // Every executed request yields exactly one result in the next cycle.
  `BRF_ASSERT_NEXT(a_exec_result, exec, res_vld_r)

endmodule

// ----- rtl/brf_out_queue.sv -----
module brf_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_vld,
  input  brf_pkg::res_t res,
  output logic          oq_room,
  output logic          empty,
  input  logic          pop,
  output brf_pkg::res_t head
);
  import brf_pkg::*;

  res_t                q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r;
  logic [OQ_PTR_W-1:0] rd_ptr_r;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic                do_pop;

  // Room is granted only while a result already in flight still fits as well.
  assign oq_room = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign empty   = (cnt_r == '0);
  assign head    = q_r[rd_ptr_r];
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_vld) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (res_vld) begin
        wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      end
      if (res_vld && !do_pop) begin
        cnt_r <= cnt_r + OQ_CNT_W'(1);
      end else if (do_pop && !res_vld) begin
        cnt_r <= cnt_r - OQ_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/broadcast_ring_fifo.sv -----
// A ring buffer with one writer whose entries are read once by each of
// several readers. Requests enter through push/full: a write stores
// in_write_value at the tail, a read returns the head entry to reader
// in_reader_id. The head entry is freed once reader_count distinct readers
// have read it. A write is refused with status 2 when the ring is full and
// with status 3 when write_limit successful writes have been made; a read
// with nothing new for that reader returns status 1. Every request yields
// exactly one result on the empty/pop side, in request order. The block
// sustains one request per clock cycle while the result queue has room; the
// slot memory has one port and each request uses it at most once. A request
// accepted into the front queue executes against the ring when it reaches the
// head of that queue; its result is registered in the back and then written
// into the result queue, from which it can be popped.
// Configuration writes take effect at once and should be made only while no
// request is outstanding.
module broadcast_ring_fifo #(
  parameter int unsigned DEPTH   = brf_pkg::DEPTH_DEF,
  parameter int unsigned READERS = brf_pkg::READERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [brf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brf_pkg::CFG_DAT_W-1:0]     cfg_data,
  // Request side.
  input  logic                              push,
  output logic                              full,
  input  logic                              in_operation,
  input  logic [brf_pkg::RID_W-1:0]         in_reader_id,
  input  logic signed [brf_pkg::VALUE_W-1:0] in_write_value,
  // Result side.
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        out_status,
  output logic signed [brf_pkg::VALUE_W-1:0] out_read_value,
  output logic [brf_pkg::POS_W-1:0]         out_slot_position
);
  import brf_pkg::*;

  // Front to back: the classified request at the head of the request queue.
  req_t req;
  logic req_vld;
  logic req_take;

  // Back to result queue.
  logic oq_room;
  logic res_vld;
  res_t res;
  res_t head;

  // The front accepts and classifies requests into a short queue, so a stalled
  // result side blocks acceptance of the next request only once that queue is full.
  brf_front #(
    .READERS(READERS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_operation  (in_operation),
    .in_reader_id  (in_reader_id),
    .in_write_value(in_write_value),
    .req           (req),
    .req_vld       (req_vld),
    .req_take      (req_take)
  );

  // The back owns the configuration, the ring state and the slot memory; it
  // executes one request per cycle whenever the result queue has room.
  brf_back #(
    .DEPTH  (DEPTH),
    .READERS(READERS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req),
    .req_vld  (req_vld),
    .req_take (req_take),
    .oq_room  (oq_room),
    .res_vld  (res_vld),
    .res      (res)
  );

  // Results wait here until the consumer pops them.
  brf_out_queue u_out_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .res_vld(res_vld),
    .res    (res),
    .oq_room(oq_room),
    .empty  (empty),
    .pop    (pop),
    .head   (head)
  );

  assign out_status        = head.status;
  assign out_read_value    = head.read_value;
  assign out_slot_position = head.slot_position;

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import brf_pkg::*;

  // The block is built with its default sizes, so the checker uses the same.
  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  localparam int unsigned READER_MAX = READERS_DEF;

  // Requests per random phase. Seven phases, together with the drains between
  // them and the directed tests, come to roughly 1750 requests.
  localparam int unsigned PHASE_REQUESTS = 210;
  localparam int unsigned PHASE_COUNT    = 7;

  // Successful writes still allowed when the limit phase starts.
  localparam int unsigned LIMIT_HEADROOM = 60;

  // Every input carries a known value from time zero.
  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index      = CFG_SLOTS_IN_USE;
  logic [CFG_DAT_W-1:0]       cfg_data       = '0;
  logic                       push           = 1'b0;
  logic                       full;
  logic                       in_operation   = OP_READ;
  logic [RID_W-1:0]           in_reader_id   = '0;
  logic signed [VALUE_W-1:0]  in_write_value = '0;
  logic                       empty;
  logic                       pop            = 1'b0;
  logic [1:0]                 out_status;
  logic signed [VALUE_W-1:0]  out_read_value;
  logic [POS_W-1:0]           out_slot_position;

  broadcast_ring_fifo dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .full              (full),
    .in_operation      (in_operation),
    .in_reader_id      (in_reader_id),
    .in_write_value    (in_write_value),
    .empty             (empty),
    .pop               (pop),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_slot_position (out_slot_position)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the ring. It is advanced once per accepted request, at the
  // clock edge that accepts it, so it always reflects every request that the
  // block has taken, even those whose responses are still in flight.
  // ---------------------------------------------------------------------------
  logic [SLOTS_W-1:0]   slots_reg;
  logic [RCNT_W-1:0]    readers_reg;
  logic [LIMIT_W-1:0]   limit_reg;
  logic [VALUE_W-1:0]   ring_mem [RING_DEPTH];
  logic [POS_W-1:0]     head_q;
  logic [POS_W-1:0]     tail_q;
  int unsigned          ring_fill;
  logic [READER_MAX-1:0] read_mask;
  int unsigned          read_tally;
  logic [LIMIT_W-1:0]   writes_total;

  // Responses that the block owes, oldest first.
  res_t expected_responses[$];

  int unsigned error_count       = 0;
  int unsigned requests_sent     = 0;
  int unsigned responses_checked = 0;
  int unsigned status_seen [4]   = '{0, 0, 0, 0};

  // Remaining requests or responses in a stretch where that side never idles.
  int unsigned send_burst = 0;
  int unsigned recv_burst = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs. A correct run needs well under a tenth
  // of this, even with every request and response meeting the longest idle.
  initial begin
    #30000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void reset_shadow();
    slots_reg    = SLOTS_RST;
    readers_reg  = RCNT_RST;
    limit_reg    = LIMIT_RST;
    head_q       = '0;
    tail_q       = '0;
    ring_fill    = 0;
    read_mask    = '0;
    read_tally   = 0;
    writes_total = '0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
  endfunction

  // Register values outside their legal range are clamped by the block.
  function automatic int unsigned live_slots();
    if (slots_reg < 1) return 1;
    if (slots_reg > RING_DEPTH) return RING_DEPTH;
    return 32'(slots_reg);
  endfunction

  function automatic int unsigned live_readers();
    if (readers_reg < 1) return 1;
    if (readers_reg > READER_MAX) return READER_MAX;
    return 32'(readers_reg);
  endfunction

  // An index at or past the wrap point goes back to slot zero.
  function automatic logic [POS_W-1:0] next_slot(logic [POS_W-1:0] idx);
    int unsigned n;
    n = int'(idx) + 1;
    return (n >= live_slots()) ? '0 : POS_W'(n);
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_SLOTS_IN_USE: slots_reg   = data[SLOTS_W-1:0];
      CFG_READER_COUNT: readers_reg = data[RCNT_W-1:0];
      CFG_WRITE_LIMIT:  limit_reg   = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the response to one request and updates the shadow ring.
  // A refused request leaves the ring untouched.
  function automatic res_t ring_response(op_t op, logic [RID_W-1:0] rid,
                                         logic signed [VALUE_W-1:0] val);
    res_t r;
    r.status     = ST_OK;
    r.read_value = '0;
    if (op == OP_WRITE) begin
      r.slot_position = tail_q;
      // Full is checked before the lifetime limit, so both at once reads as full.
      if (ring_fill >= live_slots()) begin
        r.status = ST_FULL;
      end else if (writes_total >= limit_reg) begin
        r.status = ST_LIMIT;
      end else begin
        ring_mem[tail_q] = val;
        tail_q           = next_slot(tail_q);
        ring_fill++;
        writes_total++;
      end
    end else begin
      r.slot_position = head_q;
      if (int'(rid) >= READER_MAX || ring_fill == 0 || read_mask[rid]) begin
        r.status = ST_NOTHING;
      end else begin
        r.read_value   = ring_mem[head_q];
        read_mask[rid] = 1'b1;
        read_tally++;
        // Once enough distinct readers have seen the head entry it is freed.
        if (read_tally >= live_readers()) begin
          head_q     = next_slot(head_q);
          read_mask  = '0;
          read_tally = 0;
          ring_fill--;
        end
      end
    end
    return r;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned sender_gap();
    if (send_burst != 0) begin
      send_burst--;
      return 0;
    end
    if ($urandom_range(39) == 0) send_burst = $urandom_range(120, 30);
    return idle_len();
  endfunction

  // Values at the edges of the signed range turn up more often than chance.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // The block looks only at the low bits of a narrow register, so the rest
  // of the write data is filled with noise.
  function automatic logic [CFG_DAT_W-1:0] pad_upper(logic [CFG_DAT_W-1:0] v,
                                                     int unsigned w);
    logic [CFG_DAT_W-1:0] noise;
    noise = $urandom();
    return (noise << w) | v;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. The request is held on the inputs until an edge sees full
  // low; at that edge it is taken and its response is predicted. push stays
  // high after acceptance, so a request with no gap before it follows without push dropping.
  // ---------------------------------------------------------------------------
  task automatic issue_request(op_t op, logic [RID_W-1:0] rid,
                               logic signed [VALUE_W-1:0] val);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_operation   <= op;
    in_reader_id   <= rid;
    in_write_value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_responses.push_back(ring_response(op, rid, val));
    requests_sent++;
  endtask

  task automatic send_write(logic signed [VALUE_W-1:0] val);
    issue_request(OP_WRITE, RID_W'($urandom()), val);
  endtask

  task automatic send_read(logic [RID_W-1:0] rid);
    issue_request(OP_READ, rid, $urandom());
  endtask

  // Read by a reader that has not yet seen the head entry, so that the
  // read succeeds and moves the entry toward being freed.
  task automatic read_fresh();
    int unsigned start;
    int unsigned k;
    logic [RID_W-1:0] rid;
    start = $urandom_range(READER_MAX - 1);
    rid   = RID_W'(start);
    for (k = 0; k < READER_MAX; k++) begin
      if (!read_mask[(start + k) % READER_MAX]) begin
        rid = RID_W'((start + k) % READER_MAX);
        break;
      end
    end
    send_read(rid);
  endtask

  // Empties the ring through successful reads. The ring size is only ever
  // changed while the ring is empty, so head and tail meet and every later
  // read lands on a slot that was written.
  task automatic drain_ring();
    while (ring_fill != 0) read_fresh();
  endtask

  // Lowers push and waits for every outstanding response to be checked.
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The shadow picks up the new value at the same edge as the block does.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: pop is raised for runs of random length and dropped for
  // stalls of random length, with occasional stretches of no stalls at all.
  // ---------------------------------------------------------------------------
  initial begin : pop_pacing
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      pop <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      if (recv_burst != 0) begin
        recv_burst--;
        stall = 0;
      end else begin
        if ($urandom_range(19) == 0) recv_burst = $urandom_range(30, 8);
        stall = idle_len();
      end
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Every response taken by the block's output is matched against the
  // oldest prediction, field by field.
  always @(posedge clk) begin : response_check
    res_t want;
    if (rst_n && pop && !empty) begin
      if (expected_responses.size() == 0) begin
        $error("unexpected response: status %0d read_value %0d slot_position %0d",
               out_status, out_read_value, out_slot_position);
        error_count++;
      end else begin
        want = expected_responses.pop_front();
        responses_checked++;
        status_seen[want.status]++;
        if (out_status !== want.status) begin
          $error("status: expected %s, got %0d", want.status.name(), out_status);
          error_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
          error_count++;
        end
        if (out_slot_position !== want.slot_position) begin
          $error("slot_position: expected %0d, got %0d",
                 want.slot_position, out_slot_position);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // With the reset sizes: a read of the empty ring, the two signed extremes
  // written, and a reader that asks twice for the same entry.
  task automatic test_empty_and_repeat_reads();
    send_read(3'd0);
    send_write(32'sh7FFF_FFFF);
    send_write(32'sh8000_0000);
    send_read(3'd7);
    send_read(3'd7);
    send_read(3'd3);
    wait_idle();
  endtask

  // Zero in both narrow registers clamps to one slot and one reader; later
  // the largest encodings clamp to the full ring and the full reader set,
  // the reader count changing while an entry is held and still unread.
  task automatic test_clamped_registers();
    drain_ring();
    wait_idle();
    write_register(CFG_SLOTS_IN_USE, '0);
    write_register(CFG_READER_COUNT, '0);
    send_write('1);
    send_write('0);
    send_read(3'd5);
    send_read(3'd5);
    send_write(32'sh0000_0001);
    wait_idle();
    write_register(CFG_READER_COUNT, CFG_DAT_W'(15));
    send_read(3'd2);
    drain_ring();
    wait_idle();
    write_register(CFG_SLOTS_IN_USE, CFG_DAT_W'(31));
  endtask

  // A two-slot ring with one reader: full, full and limit together, limit
  // alone, then the limit at zero and back at its maximum.
  task automatic test_full_and_write_limit();
    wait_idle();
    drain_ring();
    wait_idle();
    write_register(CFG_SLOTS_IN_USE, CFG_DAT_W'(2));
    write_register(CFG_READER_COUNT, CFG_DAT_W'(1));
    send_write(32'sh0000_0000);
    send_write(32'sh1234_5678);
    send_write(pick_value());
    wait_idle();
    write_register(CFG_WRITE_LIMIT, writes_total);
    send_write(pick_value());
    send_read(3'd2);
    send_write(pick_value());
    wait_idle();
    write_register(CFG_WRITE_LIMIT, '0);
    send_write(pick_value());
    send_read(3'd4);
    send_read(3'd6);
    wait_idle();
    write_register(CFG_WRITE_LIMIT, '1);
  endtask

  // Mixed traffic whose write share follows the fill level, so the ring
  // swings between empty and full. Most reads come from readers that still
  // owe the head entry; the rest are random and often refused.
  task automatic run_traffic(int unsigned count);
    int unsigned i;
    int unsigned write_pct;
    for (i = 0; i < count; i++) begin
      if (ring_fill == 0) write_pct = 80;
      else if (ring_fill >= live_slots()) write_pct = 15;
      else write_pct = 50;
      if ($urandom_range(99) < write_pct) begin
        send_write(pick_value());
      end else if ($urandom_range(9) < 8) begin
        read_fresh();
      end else begin
        send_read(RID_W'($urandom_range(READER_MAX - 1)));
      end
    end
  endtask

  // Random phases under a series of settings, including both ends of each
  // range, out-of-range encodings and a phase with a lowered write limit.
  // The reader count and the limit change with entries still held; the ring
  // size changes only after the ring has been drained.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned slots_pick;
    int unsigned readers_pick;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin slots_pick = 16; readers_pick = 8;  end
        1: begin slots_pick = 1;  readers_pick = 1;  end
        2: begin slots_pick = 5;  readers_pick = 3;  end
        3: begin slots_pick = 16; readers_pick = 1;  end
        4: begin slots_pick = 2;  readers_pick = 8;  end
        5: begin slots_pick = 31; readers_pick = 15; end
        default: begin
          slots_pick   = $urandom_range(RING_DEPTH, 1);
          readers_pick = $urandom_range(READER_MAX, 1);
        end
      endcase
      wait_idle();
      if (SLOTS_W'(slots_pick) != slots_reg) begin
        drain_ring();
        wait_idle();
        write_register(CFG_SLOTS_IN_USE, pad_upper(slots_pick, SLOTS_W));
      end
      write_register(CFG_READER_COUNT, pad_upper(readers_pick, RCNT_W));
      if (phase == 5) write_register(CFG_WRITE_LIMIT, writes_total + LIMIT_HEADROOM);
      else write_register(CFG_WRITE_LIMIT, '1);
      run_traffic(PHASE_REQUESTS);
    end
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_repeat_reads();
    test_clamped_registers();
    test_full_and_write_limit();
    test_random_traffic();

    // Let every response come back, then give the block time to show
    // anything it should not produce.
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (directed, then %0d random phases); checked %0d responses.",
             requests_sent, PHASE_COUNT, responses_checked);
    $display("Responses by status: ok %0d, nothing new %0d, full %0d, limit %0d.",
             status_seen[ST_OK], status_seen[ST_NOTHING], status_seen[ST_FULL],
             status_seen[ST_LIMIT]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
